@@ rtl/sorting_gate_servo_sequencer_assert.svh @@
// assertion macros shared by the checker files
`ifndef SORTING_GATE_SERVO_SEQUENCER_ASSERT_SVH
`define SORTING_GATE_SERVO_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SGSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgss assertion failed");

// next-cycle implication, disabled while in reset
`define SGSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgss assertion failed");

`endif

@@ rtl/sgss_pkg.sv @@
`timescale 1ns / 1ps
package sgss_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  // actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // materials
  localparam logic [2:0] MAT_NONE  = 3'd0;
  localparam logic [2:0] MAT_PAPER = 3'd1;
  localparam logic [2:0] MAT_CAN   = 3'd2;
  localparam logic [2:0] MAT_PET   = 3'd3;
  localparam logic [2:0] MAT_VINYL = 3'd4;

  // close reasons
  localparam logic [1:0] CLOSE_NONE    = 2'd0;
  localparam logic [1:0] CLOSE_REQUEST = 2'd1;
  localparam logic [1:0] CLOSE_TIMEOUT = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_OPEN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_OPEN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED    = 2'd2;

  localparam logic [15:0] MIN_OPEN_RESET = 16'd2000;
  localparam logic [15:0] MAX_OPEN_RESET = 16'd10000;
  localparam logic [9:0]  SPEED_RESET    = 10'd120;

  // servo angles
  localparam logic [7:0] ANG_TOP_NEUTRAL = 8'd90;
  localparam logic [7:0] ANG_TOP_PC      = 8'd30;
  localparam logic [7:0] ANG_TOP_PV      = 8'd150;
  localparam logic [7:0] ANG_PV_PET      = 8'd130;
  localparam logic [7:0] ANG_PV_VINYL    = 8'd30;
  localparam logic [7:0] ANG_PC_PAPER    = 8'd150;
  localparam logic [7:0] ANG_PC_CAN      = 8'd50;

  typedef struct packed {
    logic [15:0] min_open_ms;
    logic [15:0] max_open_ms;
    logic [9:0]  move_speed;
  } cfg_t;

  typedef struct packed {
    logic       is_open;
    logic [2:0] open_material;
    logic       close_pending;
    logic       top_move_pending;
    logic [2:0] route_material;
  } gate_state_t;

  // packed from the top down so that top_cmd lands in bit 0
  typedef struct packed {
    logic [3:0] pad;
    logic [2:0] current_type;
    logic [1:0] close_code;
    logic       gate_changed;
    logic       gate_is_open;
    logic [9:0] servo_speed;
    logic [7:0] paper_can_angle;
    logic       paper_can_cmd;
    logic [7:0] pet_vinyl_angle;
    logic       pet_vinyl_cmd;
    logic [7:0] top_angle;
    logic       top_cmd;
  } result_t;

  function automatic logic [7:0] top_angle_of(input logic [2:0] mat);
    logic [7:0] ang;
    ang = ANG_TOP_NEUTRAL;
    if (mat inside {MAT_PAPER, MAT_CAN}) begin
      ang = ANG_TOP_PC;
    end else if (mat inside {MAT_PET, MAT_VINYL}) begin
      ang = ANG_TOP_PV;
    end
    return ang;
  endfunction

endpackage

@@ rtl/sgss_step.sv @@
`timescale 1ns / 1ps
module sgss_step #(
  parameter int TIMER_BITS = 16
) (
  input  logic [1:0]            action,
  input  logic [2:0]            item_type,
  input  logic                  paper_can_moving,
  input  logic                  pet_vinyl_moving,
  input  sgss_pkg::cfg_t        cfg,
  input  sgss_pkg::gate_state_t cur,
  input  logic [TIMER_BITS-1:0] elapsed,
  output sgss_pkg::gate_state_t nxt,
  output logic [TIMER_BITS-1:0] elapsed_nxt,
  output sgss_pkg::result_t     res
);
  import sgss_pkg::*;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [TIMER_BITS-1:0] inc;
  logic [CW-1:0]         inc_ext;
  logic [CW-1:0]         max_ext;
  logic [CW-1:0]         min_ext;
  logic [1:0]            code;

  // saturating open timer
  assign inc     = (elapsed != {TIMER_BITS{1'b1}}) ? elapsed + TIMER_BITS'(1) : elapsed;
  assign inc_ext = CW'(inc);
  assign max_ext = CW'(cfg.max_open_ms);
  assign min_ext = CW'(cfg.min_open_ms);

  always_comb begin
    nxt         = cur;
    elapsed_nxt = elapsed;
    res         = '0;
    code        = CLOSE_NONE;
    case (action)
      ACT_OPEN: begin
        if (item_type inside {[MAT_PAPER:MAT_VINYL]}) begin
          res.pet_vinyl_cmd   = 1'b1;
          res.paper_can_cmd   = 1'b1;
          res.pet_vinyl_angle = (item_type == MAT_VINYL) ? ANG_PV_VINYL : ANG_PV_PET;
          res.paper_can_angle = (item_type == MAT_CAN) ? ANG_PC_CAN : ANG_PC_PAPER;
          nxt.route_material   = item_type;
          nxt.top_move_pending = 1'b1;
          nxt.is_open          = 1'b1;
          nxt.open_material    = item_type;
          nxt.close_pending    = 1'b0;
          elapsed_nxt          = '0;
        end
      end
      ACT_CLOSE: begin
        nxt.close_pending = 1'b1;
      end
      ACT_TICK: begin
        if (cur.is_open) begin
          elapsed_nxt = inc;
          if (inc_ext >= max_ext) begin
            code = CLOSE_TIMEOUT;
          end else if (cur.close_pending && (inc_ext >= min_ext)) begin
            code = CLOSE_REQUEST;
          end
          if (code != CLOSE_NONE) begin
            nxt.top_move_pending = 1'b0;
            res.top_cmd          = 1'b1;
            res.top_angle        = ANG_TOP_NEUTRAL;
            res.pet_vinyl_cmd    = 1'b1;
            res.pet_vinyl_angle  = ANG_PV_PET;
            res.paper_can_cmd    = 1'b1;
            res.paper_can_angle  = ANG_PC_PAPER;
            nxt.is_open          = 1'b0;
            nxt.open_material    = MAT_NONE;
            nxt.close_pending    = 1'b0;
            elapsed_nxt          = '0;
          end
        end
        // deferred top move once both lower servos are idle
        if (nxt.top_move_pending && !paper_can_moving && !pet_vinyl_moving) begin
          res.top_cmd          = 1'b1;
          res.top_angle        = top_angle_of(cur.route_material);
          nxt.top_move_pending = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.servo_speed  = cfg.move_speed;
    res.gate_is_open = nxt.is_open;
    res.gate_changed = nxt.is_open ^ cur.is_open;
    res.close_code   = code;
    res.current_type = nxt.open_material;
  end

endmodule

@@ rtl/sorting_gate_servo_sequencer.sv @@
`timescale 1ns / 1ps
// sorting gate servo sequencer
// in channel (in_tvalid/in_tready): in_tuser carries the action (tick, open,
// close request), in_tdata the material and the two lower servo busy flags.
// out channel (out_tvalid/out_tready): one result per input transaction with
// the three servo commands, the speed, the gate state and the close reason.
// cfg port: cfg_we writes cfg_data into register cfg_addr (0 min open time,
// 1 max open time, 2 servo speed) on the clock edge; other indexes are dropped.
// result: registered, it shows in the cycle after acceptance.
// throughput: one transaction per cycle while no result is stalled; the gate state update is a single
// pass of logic from the input port into the result and state registers.
// stall: while a result waits, in_tready follows out_tready, so a new
// transaction is taken in the same cycle the waiting result is taken.
// reset: gate closed, no pending moves, timer at zero, registers back to
// 2000 ms, 10000 ms and 120 deg/s, output empty.
module sorting_gate_servo_sequencer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // item_type[2:0], paper_can_moving[3], pet_vinyl_moving[4], zero[7:5]
  input  logic [sgss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [sgss_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // top_cmd[0], top_angle[8:1], pet_vinyl_cmd[9], pet_vinyl_angle[17:10],
  // paper_can_cmd[18], paper_can_angle[26:19], servo_speed[36:27],
  // gate_is_open[37], gate_changed[38], close_code[40:39],
  // current_type[43:41], zero[47:44]
  output logic [sgss_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [sgss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sgss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sgss_pkg::*;

  cfg_t                  cfg_r;
  gate_state_t           state_r;
  gate_state_t           state_nxt;
  logic [TIMER_BITS-1:0] elapsed_r;
  logic [TIMER_BITS-1:0] elapsed_nxt;
  result_t               res_nxt;
  result_t               res_r;
  logic                  out_valid_r;
  logic                  in_accept;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_open_ms <= MIN_OPEN_RESET;
      cfg_r.max_open_ms <= MAX_OPEN_RESET;
      cfg_r.move_speed  <= SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_OPEN: cfg_r.min_open_ms <= cfg_data;
        CFG_MAX_OPEN: cfg_r.max_open_ms <= cfg_data;
        CFG_SPEED:    cfg_r.move_speed  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  sgss_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .action           (in_tuser[1:0]),
    .item_type        (in_tdata[2:0]),
    .paper_can_moving (in_tdata[3]),
    .pet_vinyl_moving (in_tdata[4]),
    .cfg              (cfg_r),
    .cur              (state_r),
    .elapsed          (elapsed_r),
    .nxt              (state_nxt),
    .elapsed_nxt      (elapsed_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r   <= state_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ rtl/sgss_checker.sv @@
`timescale 1ns / 1ps
`include "sorting_gate_servo_sequencer_assert.svh"
module sgss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sgss_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sgss_pkg::*;

  // a stalled result holds
  `SGSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an empty output stage never blocks the input
  `SGSS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // every accepted transaction yields a result in the next cycle
  `SGSS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)

  // a gate change always commands both lower servos
  `SGSS_ASSERT_NOW(a_change_cmds, clk, rst_n, out_tvalid && out_tdata[38], out_tdata[9] && out_tdata[18])

  // a close leaves the gate shut and marks a change
  `SGSS_ASSERT_NOW(a_close_shuts, clk, rst_n, out_tvalid && (out_tdata[40:39] != CLOSE_NONE), !out_tdata[37] && out_tdata[38])

endmodule

bind sorting_gate_servo_sequencer sgss_checker u_sgss_checker (.*);
